// ----- hdl/fhc_pkg.sv -----
// Shared constants and helper function for the float/half converter.
`default_nettype none

package fhc_pkg;

   // operation codes carried on req_op
   localparam logic OP_S2H = 1'b0;
   localparam logic OP_H2S = 1'b1;

   // single to half exponent thresholds
   localparam logic [7:0] S2H_SUBNORM_MAX_EXP = 8'd112;  // 127 - 15
   localparam logic [7:0] S2H_SUBNORM_BASE    = 8'd113;  // 127 - 14
   localparam logic [7:0] S2H_ZERO_MAX_EXP    = 8'd81;   // shift of 32 or more

   // half to single exponent offsets
   localparam logic [7:0] H2S_REBIAS        = 8'd112;  // 127 - 15
   localparam logic [7:0] H2S_SUBNORM_BASE  = 8'd113;  // 127 - 14

   // Count leading zeros of a 10-bit mantissa; an all-zero input gives 10.
   function automatic logic [3:0] lead_zero_count(input logic [9:0] mant);
      logic [3:0] count;
      logic       found;
      count = 4'd10;
      found = 1'b0;
      for (int b = 9; b >= 0; b--) begin
         if (!found && mant[b]) begin
            count = 4'(9 - b);
            found = 1'b1;
         end
      end
      return count;
   endfunction

endpackage : fhc_pkg

`default_nettype wire

// ----- hdl/float_half_converter_top.sv -----
// Top level: input register, conversion logic and result register.
// An accepted request beat passes the input register, then the result register, to its response beat.
// Throughput: one beat per cycle; the input and result registers stall
// together only when the result is held and the input register is full.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
`default_nettype none

module float_half_converter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_converted
);
   import fhc_pkg::*;

   logic        in_valid_ff;
   logic        op_ff;
   logic [31:0] value_ff;
   logic        out_valid_ff;
   logic [31:0] converted_ff;
   logic [31:0] converted_in;
   logic [15:0] half_result;
   logic [31:0] single_result;
   logic        out_adv;
   logic        in_adv;

   fhc_s2h u_s2h (
      .single_bits (value_ff),
      .half_bits   (half_result)
   );

   fhc_h2s u_h2s (
      .half_bits   (value_ff[15:0]),
      .single_bits (single_result)
   );

   // select the result for the held operation
   assign converted_in = (op_ff == OP_H2S) ? single_result : {16'd0, half_result};

   // advance the result register when empty or drained, the input register behind it
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_valid;
      end
      if (in_adv && req_valid) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
      if (out_adv && in_valid_ff) begin
         converted_ff <= converted_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_converted = converted_ff;

   // hold a blocked input beat in place
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_adv) |=> (in_valid_ff && $stable(op_ff) && $stable(value_ff)))
      else $error("held input beat lost or changed");

   // stall the request side only when both registers are full and blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // move a held input beat into the result register
   a_forward: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_adv) |=> rsp_valid)
      else $error("input beat dropped on its way to the result");

   // drive zero upper bits for a single to half result
   a_half_upper: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_adv && op_ff == OP_S2H) |=> (rsp_converted[31:16] == 16'd0))
      else $error("half result has nonzero upper bits");

endmodule : float_half_converter_top

`default_nettype wire

// ----- hdl/fhc_s2h.sv -----
// Single to half bit pattern conversion, truncating, combinational.
`default_nettype none

module fhc_s2h (
   input  wire logic [31:0] single_bits,
   output logic      [15:0] half_bits
);
   import fhc_pkg::*;

   logic [7:0]  exp_single;
   logic [7:0]  shift_full;
   logic [31:0] mant_shifted;
   logic [13:0] half_mag;

   assign exp_single = single_bits[30:23];
   assign shift_full = S2H_SUBNORM_BASE - exp_single;

   // shift the mantissa with its hidden one into subnormal position
   assign mant_shifted = {8'd0, 1'b1, single_bits[22:0]} >> shift_full[4:0];

   // pick subnormal, flushed or wrapped-exponent magnitude
   always_comb begin
      if (exp_single <= S2H_ZERO_MAX_EXP) begin
         half_mag = 14'd0;
      end else if (exp_single <= S2H_SUBNORM_MAX_EXP) begin
         half_mag = {4'd0, mant_shifted[22:13]};
      end else begin
         half_mag = single_bits[26:13];
      end
   end

   // merge sign and exponent top bit
   assign half_bits = {single_bits[31:30], half_mag};

endmodule : fhc_s2h

`default_nettype wire

// ----- hdl/fhc_h2s.sv -----
// Half to single bit pattern conversion with subnormal normalization, combinational.
`default_nettype none

module fhc_h2s (
   input  wire logic [15:0] half_bits,
   output logic      [31:0] single_bits
);
   import fhc_pkg::*;

   logic [4:0]  exp_half;
   logic [9:0]  mant_half;
   logic [3:0]  norm_shift;
   logic [10:0] mant_norm;
   logic [7:0]  exp_norm;

   assign exp_half  = half_bits[14:10];
   assign mant_half = half_bits[9:0];

   // normalize a subnormal mantissa so the leading one drops off
   assign norm_shift = lead_zero_count(mant_half) + 4'd1;
   assign mant_norm  = {1'b0, mant_half} << norm_shift;
   assign exp_norm   = H2S_SUBNORM_BASE - {4'd0, norm_shift};

   // rebias normals, normalize subnormals, keep signed zero
   always_comb begin
      if (exp_half != 5'd0) begin
         single_bits = {half_bits[15], {3'd0, exp_half} + H2S_REBIAS, mant_half, 13'd0};
      end else if (mant_half != 10'd0) begin
         single_bits = {half_bits[15], exp_norm, mant_norm[9:0], 13'd0};
      end else begin
         single_bits = {half_bits[15], 31'd0};
      end
   end

endmodule : fhc_h2s

`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the float/half converter: directed table, random operands, self-checking.
`timescale 1ns / 100ps

module testbench;
   import fhc_pkg::*;

   localparam int RANDOM_OPERANDS = 750;
   localparam int QUIET_TAIL      = 100;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DIRECTED_COUNT  = 25;

   typedef struct packed {
      logic        op;
      logic [31:0] value;
      logic        known;      // expected result typed in below
      logic [31:0] converted;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_S2H;
   logic [31:0] req_value = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_converted;

   logic [31:0] pending_converted [$];
   int          converted_seen = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          quiet_tail = 1'b0;
   bit          long_hold_done = 1'b0;

   // extremes, wrap and subnormal edges of both directions
   directed_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      {OP_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},  // positive zero
      {OP_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},  // negative zero keeps sign
      {OP_S2H, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},  // all ones
      {OP_S2H, 32'h3F80_0000, 1'b1, 32'h0000_3C00},  // one
      {OP_S2H, 32'h7F80_0000, 1'b0, 32'h0},          // infinity
      {OP_S2H, 32'h7FC0_0001, 1'b0, 32'h0},          // NaN
      {OP_S2H, 32'h3800_0000, 1'b0, 32'h0},          // largest subnormal exponent
      {OP_S2H, 32'h3880_0000, 1'b0, 32'h0},          // smallest normal exponent
      {OP_S2H, 32'h28FF_FFFF, 1'b0, 32'h0},          // shift of 32, flushed
      {OP_S2H, 32'hA97F_FFFF, 1'b0, 32'h0},          // shift of 31, negative
      {OP_S2H, 32'h477F_E000, 1'b0, 32'h0},          // largest half
      {OP_S2H, 32'h4780_0000, 1'b0, 32'h0},          // exponent wraps
      {OP_S2H, 32'h7F7F_FFFF, 1'b0, 32'h0},          // largest single
      {OP_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},  // positive zero
      {OP_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},  // negative zero
      {OP_H2S, 32'h0000_3C00, 1'b1, 32'h3F80_0000},  // one
      {OP_H2S, 32'hFFFF_0000, 1'b1, 32'h0000_0000},  // upper bits ignored
      {OP_H2S, 32'hABCD_3C00, 1'b1, 32'h3F80_0000},  // upper bits ignored
      {OP_H2S, 32'h0000_0001, 1'b0, 32'h0},          // smallest subnormal
      {OP_H2S, 32'h0000_03FF, 1'b0, 32'h0},          // largest subnormal
      {OP_H2S, 32'h0000_0400, 1'b0, 32'h0},          // smallest normal
      {OP_H2S, 32'h0000_7BFF, 1'b0, 32'h0},          // largest normal
      {OP_H2S, 32'h0000_7C00, 1'b0, 32'h0},          // infinity rebiased
      {OP_H2S, 32'h0000_7FFF, 1'b0, 32'h0},          // NaN rebiased
      {OP_H2S, 32'hFFFF_FFFF, 1'b0, 32'h0}           // all ones
   };

   float_half_converter_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_converted (rsp_converted)
   );

   always #5 clock = ~clock;

   // Truncate a single to half; out-of-range exponents wrap.
   function automatic logic [15:0] single_to_half_bits(input logic [31:0] f);
      logic [7:0]  exp_f;
      logic [7:0]  shift;
      logic [31:0] shifted;
      logic [15:0] h;
      exp_f = f[30:23];
      h = 16'h0;
      if (exp_f <= S2H_SUBNORM_MAX_EXP) begin
         shift = S2H_SUBNORM_BASE - exp_f;
         if (shift < 8'd32) begin
            shifted = {8'h0, 1'b1, f[22:0]} >> shift;
            h = shifted[28:13];
         end
      end else begin
         h = {2'b00, f[26:13]};
      end
      h[15:14] = h[15:14] | f[31:30];
      return h;
   endfunction

   // Widen a half to single; exponent 31 is rebiased like any other.
   function automatic logic [31:0] half_to_single_bits(input logic [15:0] h);
      logic [31:0] f;
      logic [10:0] mant;
      logic [7:0]  norm_shift;
      f = {h[15], 31'h0};
      if (h[14:0] > 15'h03FF) begin
         f = f | (({17'h0, h[14:0]} << 13) + ({24'h0, H2S_REBIAS} << 23));
      end else if (h[9:0] != 10'h0) begin
         mant = {1'b0, h[9:0]};
         norm_shift = 8'd0;
         while (!mant[10] && norm_shift < 8'd11) begin
            mant = mant << 1;
            norm_shift++;
         end
         f[30:23] = H2S_SUBNORM_BASE - norm_shift;
         f[22:13] = mant[9:0];
      end
      return f;
   endfunction

   function automatic logic [31:0] predict_converted(input logic op, input logic [31:0] value);
      if (op == OP_H2S)
         return half_to_single_bits(value[15:0]);
      return {16'h0, single_to_half_bits(value)};
   endfunction

   // Offer one beat, hold it until accepted, then record its expected result.
   task automatic offer_operand(input logic op, input logic [31:0] value,
                                input logic known, input logic [31:0] known_converted);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      pending_converted.push_back(known ? known_converted : predict_converted(op, value));
   endtask

   // Pick an operand, weighted toward exponent edges and half special classes.
   task automatic pick_operand(output logic op, output logic [31:0] value);
      logic [7:0] exp_f;
      logic [4:0] exp_h;
      value = $urandom;
      case ($urandom_range(0, 5))
         0: op = 1'($urandom_range(0, 1));
         1: begin
            op = OP_S2H;
            value[30:23] = 8'($urandom_range(76, 116));
         end
         2: begin
            op = OP_S2H;
            case ($urandom_range(0, 2))
               0: exp_f = 8'd0;
               1: exp_f = 8'd255;
               default: exp_f = 8'($urandom_range(139, 146));
            endcase
            value[30:23] = exp_f;
         end
         3: begin
            op = OP_H2S;
            value[14:10] = 5'd0;
         end
         4: begin
            op = OP_H2S;
            case ($urandom_range(0, 2))
               0: exp_h = 5'd31;
               1: exp_h = 5'd1;
               default: exp_h = 5'd30;
            endcase
            value[14:10] = exp_h;
         end
         default: op = OP_H2S;
      endcase
   endtask

   // Stimulus: reset, directed rows, random operands, drain, verdict.
   initial begin : stimulus
      logic        op;
      logic [31:0] value;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_operand(directed_rows[i].op, directed_rows[i].value,
                       directed_rows[i].known, directed_rows[i].converted);
      for (int i = 0; i < RANDOM_OPERANDS; i++) begin
         if (i >= RANDOM_OPERANDS - QUIET_TAIL)
            quiet_tail = 1'b1;
         pick_operand(op, value);
         offer_operand(op, value, 1'b0, 32'h0);
      end
      req_valid <= 1'b0;
      while (pending_converted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Result side stall: random bursts, one long hold to back up the block.
   initial begin : result_stall
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && converted_seen >= 100) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      logic [31:0] expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         converted_seen++;
         if (pending_converted.size() == 0) begin
            $error("unexpected beat: converted actual %h", rsp_converted);
            mismatch_count++;
         end else begin
            expected = pending_converted.pop_front();
            if (rsp_converted !== expected) begin
               $error("converted: expected %h, actual %h", expected, rsp_converted);
               mismatch_count++;
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

// ----- float_half_converter_top.f -----
hdl/fhc_pkg.sv
hdl/fhc_s2h.sv
hdl/fhc_h2s.sv
hdl/float_half_converter_top.sv
dv/testbench.sv
